>>> design/rounded_border_pixel_generator_assert.svh
// Assertion macros shared by the rounded border pixel generator modules.
`ifndef ROUNDED_BORDER_PIXEL_GENERATOR_ASSERT_SVH
`define ROUNDED_BORDER_PIXEL_GENERATOR_ASSERT_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

>>> design/rbpg_pkg.sv
// Types and constants shared by the rounded border pixel generator modules.
package rbpg_pkg;

   typedef enum logic [3:0] {
      CSR_FRAME_WIDTH    = 4'd0,
      CSR_FRAME_HEIGHT   = 4'd1,
      CSR_BAND_THICKNESS = 4'd2,
      CSR_OPACITY        = 4'd3,
      CSR_ROUNDED_MODE   = 4'd4,
      CSR_CUSTOM_ENABLE  = 4'd5,
      CSR_CUSTOM_COLOR   = 4'd6,
      CSR_ACCENT_COLOR   = 4'd7
   } csr_index_type;

   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [13:0] FRAME_WIDTH_RESET  = 14'd1;
   localparam logic [13:0] FRAME_HEIGHT_RESET = 14'd1;
   localparam logic [7:0]  THICKNESS_RESET    = 8'd4;
   localparam logic [6:0]  OPACITY_RESET      = 7'd100;
   localparam logic [6:0]  OPACITY_FULL       = 7'd100;

   // 5243 / 2^19 approximates 1/100 closely enough for values up to 100*255.
   localparam logic [12:0] ALPHA_RECIP = 13'd5243;
   localparam int          ALPHA_SHIFT = 19;

   // Cycles the derived configuration needs to settle after a register write.
   localparam logic [1:0] SETTLE_CYCLES = 2'd3;

   // Configuration values prepared for the pixel pipeline.
   typedef struct packed {
      logic [13:0]        width;
      logic [13:0]        height;
      logic [7:0]         thick;
      logic [9:0]         lo;
      logic signed [15:0] w_mt;
      logic signed [15:0] h_mt;
      logic signed [15:0] hx;
      logic signed [15:0] hy;
      logic [17:0]        rad_sq;
      logic               rounded;
      logic [31:0]        pixel;
   } cfg_derived_type;

endpackage

>>> design/rbpg_csr.sv
// Configuration registers and the values derived from them for the pixel pipeline.
`include "rounded_border_pixel_generator_assert.svh"

module rbpg_csr #(
   parameter int MAX_DIMENSION = 8192
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   input  logic [rbpg_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [rbpg_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata,
   output logic                                   csr_ready,
   output logic                                   busy,
   output rbpg_pkg::cfg_derived_type              cfg
);
   import rbpg_pkg::*;

   localparam logic [16:0] MaxDim = 17'(MAX_DIMENSION);

   logic [13:0] frame_width_ff, frame_width_in;
   logic [13:0] frame_height_ff, frame_height_in;
   logic [7:0]  thick_ff, thick_in;
   logic [6:0]  opacity_ff, opacity_in;
   logic        rounded_ff, rounded_in;
   logic        custom_en_ff, custom_en_in;
   logic [23:0] custom_color_ff, custom_color_in;
   logic [23:0] accent_color_ff, accent_color_in;
   logic [1:0]  settle_ff, settle_in;

   logic        wr;
   logic [13:0] w_sat, h_sat;
   logic [9:0]  lo;
   logic [8:0]  rad;
   logic [6:0]  pct;
   logic [14:0] pct_x255;
   logic [26:0] alpha_prod;
   logic [7:0]  alpha_ff, alpha_in;
   logic [23:0] color;
   logic [15:0] chan_prod_ff [3];
   logic [15:0] chan_prod_in [3];
   logic [31:0] pixel_ff, pixel_in;
   cfg_derived_type geom_ff, geom_in;

   function automatic logic [7:0] div255(input logic [15:0] p);
      logic [16:0] s;
      s = 17'(p) + 17'(p[15:8]) + 17'd1;
      return s[15:8];
   endfunction

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;
   assign busy      = (settle_ff != 2'd0);

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      thick_in        = thick_ff;
      opacity_in      = opacity_ff;
      rounded_in      = rounded_ff;
      custom_en_in    = custom_en_ff;
      custom_color_in = custom_color_ff;
      accent_color_in = accent_color_ff;
      if (wr) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:    frame_width_in  = csr_wdata[13:0];
            CSR_FRAME_HEIGHT:   frame_height_in = csr_wdata[13:0];
            CSR_BAND_THICKNESS: thick_in        = csr_wdata[7:0];
            CSR_OPACITY:        opacity_in      = csr_wdata[6:0];
            CSR_ROUNDED_MODE:   rounded_in      = csr_wdata[0];
            CSR_CUSTOM_ENABLE:  custom_en_in    = csr_wdata[0];
            CSR_CUSTOM_COLOR:   custom_color_in = csr_wdata[23:0];
            CSR_ACCENT_COLOR:   accent_color_in = csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (wr) begin
         settle_in = SETTLE_CYCLES;
      end else if (settle_ff != 2'd0) begin
         settle_in = settle_ff - 2'd1;
      end else begin
         settle_in = settle_ff;
      end
   end

   // Frame geometry; corner circle centers lie three thicknesses in from each edge.
   always_comb begin
      w_sat = ({3'b0, frame_width_ff} > MaxDim) ? MaxDim[13:0] : frame_width_ff;
      h_sat = ({3'b0, frame_height_ff} > MaxDim) ? MaxDim[13:0] : frame_height_ff;
      lo    = {1'b0, thick_ff, 1'b0} + {2'b0, thick_ff};
      rad   = {thick_ff, 1'b0};
      geom_in.width   = w_sat;
      geom_in.height  = h_sat;
      geom_in.thick   = thick_ff;
      geom_in.lo      = lo;
      geom_in.w_mt    = $signed({2'b0, w_sat}) - $signed({8'b0, thick_ff});
      geom_in.h_mt    = $signed({2'b0, h_sat}) - $signed({8'b0, thick_ff});
      geom_in.hx      = $signed({2'b0, w_sat}) - $signed({6'b0, lo});
      geom_in.hy      = $signed({2'b0, h_sat}) - $signed({6'b0, lo});
      geom_in.rad_sq  = 18'(rad) * 18'(rad);
      geom_in.rounded = rounded_ff;
      geom_in.pixel   = pixel_ff;
   end

   // Alpha, then the premultiplied color, over three register stages.
   always_comb begin
      pct        = (opacity_ff > OPACITY_FULL) ? OPACITY_FULL : opacity_ff;
      pct_x255   = {pct, 8'b0} - {8'b0, pct};
      alpha_prod = 27'(pct_x255) * 27'(ALPHA_RECIP);
      alpha_in   = alpha_prod[ALPHA_SHIFT+7:ALPHA_SHIFT];
      color      = custom_en_ff ? custom_color_ff : accent_color_ff;
      for (int i = 0; i < 3; i++) begin
         chan_prod_in[i] = 16'(color[8*i +: 8]) * 16'(alpha_ff);
      end
      pixel_in = {alpha_ff, div255(chan_prod_ff[0]), div255(chan_prod_ff[1]),
                  div255(chan_prod_ff[2])};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         thick_ff        <= THICKNESS_RESET;
         opacity_ff      <= OPACITY_RESET;
         rounded_ff      <= 1'b0;
         custom_en_ff    <= 1'b0;
         custom_color_ff <= '0;
         accent_color_ff <= '0;
         settle_ff       <= SETTLE_CYCLES;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         thick_ff        <= thick_in;
         opacity_ff      <= opacity_in;
         rounded_ff      <= rounded_in;
         custom_en_ff    <= custom_en_in;
         custom_color_ff <= custom_color_in;
         accent_color_ff <= accent_color_in;
         settle_ff       <= settle_in;
      end
   end

   always_ff @(posedge clock) begin
      alpha_ff     <= alpha_in;
      chan_prod_ff <= chan_prod_in;
      pixel_ff     <= pixel_in;
      geom_ff      <= geom_in;
   end

   assign cfg = geom_ff;

   `ASSERT_NEXT(a_write_holds_off, clock, reset, wr, busy, "no hold-off after a register write")
   `ASSERT_IMPLY(a_channels_below_alpha, clock, reset, !busy, (pixel_ff[23:16] <= pixel_ff[31:24]) && (pixel_ff[15:8] <= pixel_ff[31:24]) && (pixel_ff[7:0] <= pixel_ff[31:24]), "premultiplied channel exceeds alpha")

endmodule

>>> design/rbpg_pipe.sv
// Pixel pipeline: input register, band and corner tests with squares, result register.
`include "rounded_border_pixel_generator_assert.svh"

module rbpg_pipe (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [12:0]                in_x,
   input  logic [12:0]                in_y,
   input  rbpg_pkg::cfg_derived_type  cfg,
   output logic                       out_valid,
   output logic [31:0]                out_argb
);
   import rbpg_pkg::*;

   logic        s1_valid_ff;
   logic [12:0] s1_x_ff, s1_y_ff;

   logic        s2_valid_ff;
   logic        s2_draw_ff, s2_draw_in;
   logic        s2_lt_ff, s2_lt_in, s2_rt_ff, s2_rt_in;
   logic        s2_lb_ff, s2_lb_in, s2_rb_ff, s2_rb_in;
   logic [27:0] sq_xl_ff, sq_xl_in, sq_xr_ff, sq_xr_in;
   logic [27:0] sq_yt_ff, sq_yt_in, sq_yb_ff, sq_yb_in;

   logic        rsp_valid_ff;
   logic [31:0] rsp_argb_ff, rsp_argb_in;

   logic signed [15:0] xs, ys, lo_s;
   logic signed [15:0] dx_l, dx_r, dy_t, dy_b;
   logic signed [31:0] p_xl, p_xr, p_yt, p_yb;
   logic               in_frame, band, left, right, top, bottom;
   logic [28:0]        d_lt, d_rt, d_lb, d_rb, r2;
   logic               clip;

   logic               rsp_drawn, rsp_alpha_ok, s2_skip;

   // Stage one: frame and band tests, distances to the corner centers and their squares.
   always_comb begin
      xs       = $signed({3'b0, s1_x_ff});
      ys       = $signed({3'b0, s1_y_ff});
      lo_s     = $signed({6'b0, cfg.lo});
      in_frame = ({1'b0, s1_x_ff} < cfg.width) && ({1'b0, s1_y_ff} < cfg.height);
      band     = (s1_x_ff < {5'b0, cfg.thick}) || (xs >= cfg.w_mt) ||
                 (s1_y_ff < {5'b0, cfg.thick}) || (ys >= cfg.h_mt);
      left   = s1_x_ff < {3'b0, cfg.lo};
      top    = s1_y_ff < {3'b0, cfg.lo};
      right  = xs >= cfg.hx;
      bottom = ys >= cfg.hy;
      dx_l   = xs - lo_s;
      dx_r   = xs - cfg.hx;
      dy_t   = ys - lo_s;
      dy_b   = ys - cfg.hy;
      p_xl   = dx_l * dx_l;
      p_xr   = dx_r * dx_r;
      p_yt   = dy_t * dy_t;
      p_yb   = dy_b * dy_b;
      sq_xl_in   = p_xl[27:0];
      sq_xr_in   = p_xr[27:0];
      sq_yt_in   = p_yt[27:0];
      sq_yb_in   = p_yb[27:0];
      s2_draw_in = in_frame && band;
      s2_lt_in   = cfg.rounded && left && top;
      s2_rt_in   = cfg.rounded && right && top;
      s2_lb_in   = cfg.rounded && left && bottom;
      s2_rb_in   = cfg.rounded && right && bottom;
   end

   // Stage two: a band pixel is clipped if any corner square it lies in puts it
   // outside that corner's circle.
   always_comb begin
      d_lt = {1'b0, sq_xl_ff} + {1'b0, sq_yt_ff};
      d_rt = {1'b0, sq_xr_ff} + {1'b0, sq_yt_ff};
      d_lb = {1'b0, sq_xl_ff} + {1'b0, sq_yb_ff};
      d_rb = {1'b0, sq_xr_ff} + {1'b0, sq_yb_ff};
      r2   = {11'b0, cfg.rad_sq};
      clip = (s2_lt_ff && (d_lt > r2)) || (s2_rt_ff && (d_rt > r2)) ||
             (s2_lb_ff && (d_lb > r2)) || (s2_rb_ff && (d_rb > r2));
      rsp_argb_in = (s2_draw_ff && !clip) ? cfg.pixel : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= in_valid;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_x_ff     <= in_x;
      s1_y_ff     <= in_y;
      s2_draw_ff  <= s2_draw_in;
      s2_lt_ff    <= s2_lt_in;
      s2_rt_ff    <= s2_rt_in;
      s2_lb_ff    <= s2_lb_in;
      s2_rb_ff    <= s2_rb_in;
      sq_xl_ff    <= sq_xl_in;
      sq_xr_ff    <= sq_xr_in;
      sq_yt_ff    <= sq_yt_in;
      sq_yb_ff    <= sq_yb_in;
      rsp_argb_ff <= rsp_argb_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_argb  = rsp_argb_ff;

   assign rsp_drawn    = rsp_valid_ff && (rsp_argb_ff != '0);
   assign rsp_alpha_ok = (rsp_argb_ff[31:24] == cfg.pixel[31:24]);
   assign s2_skip      = s2_valid_ff && !s2_draw_ff;

   `ASSERT_IMPLY(a_rsp_follows_req, clock, reset, rsp_valid_ff, $past(in_valid, 3), "orphan result")
   `ASSERT_IMPLY(a_alpha_matches, clock, reset, rsp_drawn, rsp_alpha_ok, "wrong alpha on a drawn pixel")
   `ASSERT_NEXT(a_undrawn_is_zero, clock, reset, s2_skip, rsp_argb_ff == '0, "undrawn pixel not zero")

endmodule

>>> design/rounded_border_pixel_generator.sv
// Top level of the rounded border pixel generator.
//
// A pixel coordinate is taken on req_pixel_x / req_pixel_y with start; the transfer
// happens at a rising edge where start is high and busy is low. The premultiplied
// ARGB value of that pixel passes the input, stage-two and result registers and
// appears on rsp_argb_value, marked by rsp_valid for exactly one cycle. While busy
// is low a new pixel can be taken every cycle, so a full frame streams at one pixel
// per clock; results leave in order. The receiver cannot stall: each result must be
// taken in its one valid cycle. Registers are written through the csr_ channel,
// whose ready is always high. After a register write, and after reset, busy stays
// high while the derived alpha, premultiplied color and corner geometry are
// recomputed. The color takes four register stages; a new pixel reads the geometry
// in stage one and the color in stage two. Writes are expected only while no pixel
// is in flight. Reset is synchronous and loads the register defaults: a 1 x 1 frame,
// a band of four pixels, full opacity, square corners and the accent color (zero).
// Frame dimensions saturate at MAX_DIMENSION.
module rounded_border_pixel_generator #(
   parameter int MAX_DIMENSION = 8192
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [12:0]                            req_pixel_x,
   input  logic [12:0]                            req_pixel_y,
   output logic                                   rsp_valid,
   output logic [31:0]                            rsp_argb_value,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [rbpg_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [rbpg_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import rbpg_pkg::*;

   cfg_derived_type cfg;
   logic            accept;

   assign accept = start && !busy;

   rbpg_csr #(
      .MAX_DIMENSION (MAX_DIMENSION)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_ready (csr_ready),
      .busy      (busy),
      .cfg       (cfg)
   );

   rbpg_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_x      (req_pixel_x),
      .in_y      (req_pixel_y),
      .cfg       (cfg),
      .out_valid (rsp_valid),
      .out_argb  (rsp_argb_value)
   );

endmodule

>>> test/tb_rounded_border_pixel_generator.sv
// Self-checking testbench for the rounded border pixel generator.
`timescale 1ns / 100ps

module tb_rounded_border_pixel_generator;
   import rbpg_pkg::*;

   localparam int FRAME_LIMIT = 8192;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 4;

   typedef struct {
      logic [12:0] x;
      logic [12:0] y;
   } pixel_coord_type;

   typedef struct {
      pixel_coord_type at;
      logic [31:0]     argb;
   } argb_due_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [12:0] req_pixel_x = '0;
   logic [12:0] req_pixel_y = '0;
   logic rsp_valid;
   logic [31:0] rsp_argb_value;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   // Local copy of the register file, used by the pixel predictor.
   logic [13:0] cfg_width = FRAME_WIDTH_RESET;
   logic [13:0] cfg_height = FRAME_HEIGHT_RESET;
   logic [7:0]  cfg_thick = THICKNESS_RESET;
   logic [6:0]  cfg_opacity = OPACITY_RESET;
   logic        cfg_rounded = 1'b0;
   logic        cfg_custom_en = 1'b0;
   logic [23:0] cfg_custom = '0;
   logic [23:0] cfg_accent = '0;

   pixel_coord_type pending_pixels[$];
   argb_due_type    due_argb[$];
   int idle_percent = 26;
   int failures = 0;
   int cycle_count = 0;

   rounded_border_pixel_generator #(
      .MAX_DIMENSION(FRAME_LIMIT)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_pixel_x(req_pixel_x),
      .req_pixel_y(req_pixel_y),
      .rsp_valid(rsp_valid),
      .rsp_argb_value(rsp_argb_value),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [7:0] scale_channel(logic [7:0] level, int unsigned alpha);
      int unsigned product;
      product = level * alpha / 255;
      return product[7:0];
   endfunction

   function automatic bit beyond_arc(longint px, longint py, longint cx, longint cy,
                                     longint rad);
      longint dx, dy;
      dx = px - cx;
      dy = py - cy;
      return dx * dx + dy * dy > rad * rad;
   endfunction

   function automatic logic [31:0] border_argb(logic [12:0] px, logic [12:0] py);
      longint x, y, w, h, t, rad, lo, hx, hy;
      int unsigned pct, alpha;
      logic [23:0] color;
      logic [31:0] drawn;
      bit band, clipped, left, right, top, bottom;
      x = px;
      y = py;
      w = (cfg_width > FRAME_LIMIT) ? FRAME_LIMIT : cfg_width;
      h = (cfg_height > FRAME_LIMIT) ? FRAME_LIMIT : cfg_height;
      t = cfg_thick;
      pct = (cfg_opacity > OPACITY_FULL) ? OPACITY_FULL : cfg_opacity;
      alpha = pct * 255 / 100;
      color = cfg_custom_en ? cfg_custom : cfg_accent;
      // The color register holds red in its low byte; the output puts red above green.
      drawn = {alpha[7:0], scale_channel(color[7:0], alpha),
               scale_channel(color[15:8], alpha), scale_channel(color[23:16], alpha)};
      if (x >= w || y >= h)
         return '0;
      band = x < t || x >= w - t || y < t || y >= h - t;
      if (!band)
         return '0;
      clipped = 1'b0;
      if (cfg_rounded) begin
         rad = 2 * t;
         lo = t + rad;
         hx = w - t - rad;
         hy = h - t - rad;
         left = x < lo;
         right = x >= hx;
         top = y < lo;
         bottom = y >= hy;
         if (left && top && beyond_arc(x, y, lo, lo, rad)) clipped = 1'b1;
         if (right && top && beyond_arc(x, y, hx, lo, rad)) clipped = 1'b1;
         if (left && bottom && beyond_arc(x, y, lo, hy, rad)) clipped = 1'b1;
         if (right && bottom && beyond_arc(x, y, hx, hy, rad)) clipped = 1'b1;
      end
      return clipped ? 32'd0 : drawn;
   endfunction

   // Driver: keeps start high until the transfer, then picks the next pixel or idles.
   always @(posedge clock) begin : pixel_driver
      pixel_coord_type next_pixel;
      argb_due_type due;
      logic taken;
      if (reset) begin
         start <= 1'b0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            due.at.x = req_pixel_x;
            due.at.y = req_pixel_y;
            due.argb = border_argb(req_pixel_x, req_pixel_y);
            due_argb = {due_argb, due};
         end
         if (!start || taken) begin
            if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= idle_percent) begin
               next_pixel = pending_pixels.pop_front();
               start <= 1'b1;
               req_pixel_x <= next_pixel.x;
               req_pixel_y <= next_pixel.y;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : argb_monitor
      argb_due_type due;
      if (!reset && rsp_valid) begin
         if (due_argb.size() == 0) begin
            failures++;
            $display("%0t: unexpected result: expected none, actual %h", $time,
                     rsp_argb_value);
         end else begin
            due = due_argb.pop_front();
            if (rsp_argb_value !== due.argb) begin
               failures++;
               $display("%0t: argb_value mismatch at pixel (%0d,%0d): expected %h, actual %h",
                        $time, due.at.x, due.at.y, due.argb, rsp_argb_value);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_pixels.size() != 0 || start || due_argb.size() != 0);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_FRAME_WIDTH:    cfg_width = value[13:0];
         CSR_FRAME_HEIGHT:   cfg_height = value[13:0];
         CSR_BAND_THICKNESS: cfg_thick = value[7:0];
         CSR_OPACITY:        cfg_opacity = value[6:0];
         CSR_ROUNDED_MODE:   cfg_rounded = value[0];
         CSR_CUSTOM_ENABLE:  cfg_custom_en = value[0];
         CSR_CUSTOM_COLOR:   cfg_custom = value[23:0];
         CSR_ACCENT_COLOR:   cfg_accent = value[23:0];
         default: ;
      endcase
   endtask

   // Called only once every pixel has come back; returns at a falling edge.
   task automatic program_frame(int w, int h, int t, int opacity, int rounded, int custom_en,
                                int custom, int accent);
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
      write_reg(CSR_BAND_THICKNESS, t);
      write_reg(CSR_OPACITY, opacity);
      write_reg(CSR_ROUNDED_MODE, rounded);
      write_reg(CSR_CUSTOM_ENABLE, custom_en);
      write_reg(CSR_CUSTOM_COLOR, custom);
      write_reg(CSR_ACCENT_COLOR, accent);
      @(negedge clock);
   endtask

   task automatic add_pixel(int x, int y);
      pixel_coord_type p;
      p.x = 13'(x);
      p.y = 13'(y);
      pending_pixels = {pending_pixels, p};
   endtask

   function automatic int pick_dimension();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 16383;
         2: return FRAME_LIMIT;
         3: return $urandom_range(0, 16383);
         default: return $urandom_range(1, 120);
      endcase
   endfunction

   function automatic int coord_near(int limit, int reach);
      return $urandom_range(0, 1) ? $urandom_range(0, reach)
                                  : limit - 1 - int'($urandom_range(0, reach));
   endfunction

   function automatic int coord_any(int limit);
      return (limit > 0) ? $urandom_range(0, limit - 1) : $urandom_range(0, 8191);
   endfunction

   // Most pixels land in the corner squares and the band, where the geometry lives.
   function automatic pixel_coord_type make_pixel();
      int w, h, t, kind, x, y;
      pixel_coord_type p;
      w = (cfg_width > FRAME_LIMIT) ? FRAME_LIMIT : cfg_width;
      h = (cfg_height > FRAME_LIMIT) ? FRAME_LIMIT : cfg_height;
      t = cfg_thick;
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
         x = coord_near(w, 3 * t + 3);
         y = coord_near(h, 3 * t + 3);
      end else if (kind < 70) begin
         x = coord_any(w);
         y = coord_any(h);
      end else if (kind < 80) begin
         if ($urandom_range(0, 1)) begin
            x = coord_near(w, t + 1);
            y = coord_any(h);
         end else begin
            x = coord_any(w);
            y = coord_near(h, t + 1);
         end
      end else begin
         x = $urandom_range(0, 8191);
         y = $urandom_range(0, 8191);
      end
      if (x < 0 || x > 8191) x = $urandom_range(0, 8191);
      if (y < 0 || y > 8191) y = $urandom_range(0, 8191);
      p.x = 13'(x);
      p.y = 13'(y);
      return p;
   endfunction

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset configuration: a one-pixel frame, everything else lies outside it.
      add_pixel(0, 0);
      add_pixel(8191, 8191);
      add_pixel(0, 8191);
      wait_idle();

      // Small rounded frame: clipped corners, arc edge, interior and outside pixels.
      program_frame(64, 48, 4, 100, 1, 1, 24'hFFFFFF, 24'h000000);
      add_pixel(0, 0);
      add_pixel(63, 47);
      add_pixel(3, 3);
      add_pixel(6, 6);
      add_pixel(7, 7);
      add_pixel(32, 0);
      add_pixel(32, 24);
      add_pixel(64, 10);
      add_pixel(10, 48);
      add_pixel(3, 30);
      wait_idle();

      // Empty frame.
      program_frame(16383, 0, 255, 127, 1, 0, 24'h00ABCD, 24'hFFFFFF);
      add_pixel(0, 0);
      add_pixel(8191, 0);
      wait_idle();

      // Oversized frame with the widest band and opacity above range.
      program_frame(16383, FRAME_LIMIT, 255, 127, 1, 0, 24'h000000, 24'hFFFFFF);
      add_pixel(0, 0);
      add_pixel(8191, 8191);
      add_pixel(100, 4096);
      add_pixel(4096, 4096);
      wait_idle();

      // Band wider than half the frame, first fully transparent, then rounded.
      program_frame(10, 7, 255, 0, 0, 1, 24'hFFFFFF, 24'h000000);
      add_pixel(5, 3);
      add_pixel(9, 6);
      wait_idle();
      program_frame(10, 7, 6, 55, 1, 1, 24'h123456, 24'h000000);
      add_pixel(5, 3);
      add_pixel(0, 0);
      add_pixel(9, 6);
      wait_idle();

      for (int phase = 0; phase < 8; phase++) begin
         program_frame(pick_dimension(), pick_dimension(),
                       ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 12),
                       ($urandom_range(0, 5) == 0) ? $urandom_range(101, 127)
                                                   : $urandom_range(0, 100),
                       $urandom_range(0, 3) != 0, $urandom_range(0, 1),
                       $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF));
         idle_percent = (phase == 2) ? 0 : 26;
         // The sender drains the pipeline halfway through each phase.
         for (int half = 0; half < 2; half++) begin
            repeat (25) pending_pixels = {pending_pixels, make_pixel()};
            wait_idle();
         end
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (due_argb.size() != 0) begin
         failures++;
         $display("%0t: %0d results never arrived", $time, due_argb.size());
      end
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
